// File: sv/blavg_pkg.sv
package blavg_pkg;

    localparam int RAW_W   = 12;
    localparam int RES_W   = 10;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;
    localparam int ADC_W   = 12;
    localparam int PROD_W  = 24;
    localparam int DIV_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ADC_W-1:0]  ADC_FULL_MV  = 12'd3550;
    localparam logic [ADC_W-1:0]  ADC_MAX_CODE = 12'd4095;
    localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_EMPTY    = 7'd0;
    localparam logic [MV_W-1:0]   MV_MAX       = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_KOHM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_KOHM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV   = 2'd3;

    localparam logic [RES_W-1:0] RST_UPPER_KOHM = 10'd100;
    localparam logic [RES_W-1:0] RST_LOWER_KOHM = 10'd100;
    localparam logic [MV_W-1:0]  RST_FULL_MV    = 16'd4200;
    localparam logic [MV_W-1:0]  RST_EMPTY_MV   = 16'd3300;

    typedef enum logic [1:0] {
        DS_RATIO = 2'd0,
        DS_AVG   = 2'd1,
        DS_PCT   = 2'd2
    } t_div_sel;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_MUL_ADC = 13'b0000000000010,
        S_ADC     = 13'b0000000000100,
        S_MUL_RAT = 13'b0000000001000,
        S_GO_RAT  = 13'b0000000010000,
        S_DIV_RAT = 13'b0000000100000,
        S_UPDATE  = 13'b0000001000000,
        S_GO_AVG  = 13'b0000010000000,
        S_DIV_AVG = 13'b0000100000000,
        S_PCT     = 13'b0001000000000,
        S_GO_PCT  = 13'b0010000000000,
        S_DIV_PCT = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic     in_ready;
        logic     load_in;
        logic     mul_adc;
        logic     mul_ratio;
        logic     mul_pct;
        logic     div_go;
        t_div_sel div_sel;
        logic     latch_adc;
        logic     latch_mv;
        logic     update;
        logic     latch_avg;
        logic     latch_pct;
        logic     pct_direct;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic taken;
        logic pct_in_range;
        logic out_free;
    } t_status;

endpackage

// File: sv/blavg_if.sv
interface blavg_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] raw_sample;
    logic        read_ok;

    modport source (output valid, output raw_sample, output read_ok, input ready);
    modport sink   (input valid, input raw_sample, input read_ok, output ready);
endinterface

interface blavg_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  level_percent;
    logic [15:0] average_mv;
    logic        sample_taken;

    modport source (output valid, output level_percent, output average_mv,
                    output sample_taken, input ready);
    modport sink   (input valid, input level_percent, input average_mv,
                    input sample_taken, output ready);
endinterface

// File: sv/blavg_div.sv
module blavg_div #(
    parameter int DW = 24,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_den;
    logic [VW:0]      n_shift;
    logic [VW:0]      n_diff;
    logic             n_ge;

    assign n_shift = {r_rem, r_quo[DW-1]};
    assign n_ge    = n_shift >= {1'b0, r_den};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[VW-1:0] : n_shift[VW-1:0];
            r_quo <= {r_quo[DW-2:0], n_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
endmodule

// File: sv/blavg_datapath.sv
module blavg_datapath #(
    parameter int WINDOW_SAMPLES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  blavg_pkg::t_cmd                     i_cmd,
    output blavg_pkg::t_status                  o_status,
    input  logic                                i_cfg_we,
    input  logic [blavg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [blavg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [blavg_pkg::RAW_W-1:0]         i_raw_sample,
    input  logic                                i_read_ok,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [blavg_pkg::PCT_W-1:0]         o_level_percent,
    output logic [blavg_pkg::MV_W-1:0]          o_average_mv,
    output logic                                o_sample_taken
);
    import blavg_pkg::*;

    localparam int IW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int SW = MV_W + $clog2(WINDOW_SAMPLES);
    localparam int CW = $clog2(WINDOW_SAMPLES + 1);
    localparam int DW = (SW > PROD_W) ? SW : PROD_W;

    logic [RES_W-1:0]  r_upper;
    logic [RES_W-1:0]  r_lower;
    logic [MV_W-1:0]   r_full_mv;
    logic [MV_W-1:0]   r_empty_mv;

    logic [MV_W-1:0]   r_ring [WINDOW_SAMPLES];
    logic [MV_W-1:0]   r_old;
    logic [IW-1:0]     r_idx;
    logic              r_full;
    logic [SW-1:0]     r_sum;
    logic [MV_W-1:0]   r_held_avg;
    logic [PCT_W-1:0]  r_held_pct;

    logic [RAW_W-1:0]  r_raw;
    logic              r_ok;
    logic [PROD_W-1:0] r_prod;
    logic [ADC_W-1:0]  r_adc;
    logic [MV_W-1:0]   r_mv;

    logic              r_out_valid;
    logic [PCT_W-1:0]  r_out_pct;
    logic [MV_W-1:0]   r_out_avg;
    logic              r_out_taken;

    logic [RES_W:0]    n_ratio;
    logic [CW-1:0]     n_count;
    logic [DW-1:0]     n_dividend;
    logic [DIV_W-1:0]  n_divisor;
    logic [DW-1:0]     n_quo;
    logic              n_div_done;
    logic              n_ge_full;
    logic              n_le_empty;
    logic              n_taken;
    logic              n_out_free;
    logic [SW-1:0]     n_drop;
    logic [ADC_W:0]    n_adc_fold;
    logic [ADC_W-1:0]  n_adc;

    assign n_ratio    = {1'b0, r_upper} + {1'b0, r_lower};
    assign n_count    = r_full ? CW'(WINDOW_SAMPLES) : CW'(r_idx);
    assign n_ge_full  = r_held_avg >= r_full_mv;
    assign n_le_empty = r_held_avg <= r_empty_mv;
    assign n_taken    = r_ok && (r_mv != '0);
    assign n_out_free = !r_out_valid || i_out_ready;
    assign n_drop     = r_full ? SW'(r_old) : '0;

    // divide by 4095: fold the high half onto the low half
    assign n_adc_fold = {1'b0, r_prod[PROD_W-1:ADC_W]} + {1'b0, r_prod[ADC_W-1:0]};
    assign n_adc      = r_prod[PROD_W-1:ADC_W]
                      + ADC_W'(n_adc_fold >= {1'b0, ADC_MAX_CODE});

    always_comb begin
        unique case (i_cmd.div_sel)
            DS_RATIO: begin
                n_dividend = DW'(r_prod);
                n_divisor  = DIV_W'(r_lower);
            end
            DS_AVG: begin
                n_dividend = DW'(r_sum);
                n_divisor  = DIV_W'(n_count);
            end
            DS_PCT: begin
                n_dividend = DW'(r_prod);
                n_divisor  = r_full_mv - r_empty_mv;
            end
            default: begin
                n_dividend = DW'(r_prod);
                n_divisor  = DIV_W'(r_lower);
            end
        endcase
    end

    blavg_div #(
        .DW (DW),
        .VW (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_quotient (n_quo),
        .o_done     (n_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper    <= RST_UPPER_KOHM;
            r_lower    <= RST_LOWER_KOHM;
            r_full_mv  <= RST_FULL_MV;
            r_empty_mv <= RST_EMPTY_MV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_UPPER_KOHM: r_upper    <= i_cfg_data[RES_W-1:0];
                REG_LOWER_KOHM: r_lower    <= i_cfg_data[RES_W-1:0];
                REG_FULL_MV:    r_full_mv  <= i_cfg_data[MV_W-1:0];
                REG_EMPTY_MV:   r_empty_mv <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_old <= r_ring[r_idx];
        end
        if (i_cmd.update) begin
            r_ring[r_idx] <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_full     <= 1'b0;
            r_sum      <= '0;
            r_held_avg <= '0;
            r_held_pct <= PCT_FULL;
        end else begin
            if (i_cmd.update) begin
                r_sum <= r_sum - n_drop + SW'(r_mv);
                if (r_idx == IW'(WINDOW_SAMPLES - 1)) begin
                    r_idx  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.latch_avg) begin
                r_held_avg <= n_quo[MV_W-1:0];
            end
            if (i_cmd.latch_pct) begin
                r_held_pct <= n_quo[PCT_W-1:0];
            end else if (i_cmd.pct_direct) begin
                r_held_pct <= n_ge_full ? PCT_FULL : PCT_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw <= i_raw_sample;
            r_ok  <= i_read_ok;
        end
        if (i_cmd.mul_adc) begin
            r_prod <= PROD_W'(r_raw) * PROD_W'(ADC_FULL_MV);
        end else if (i_cmd.mul_ratio) begin
            r_prod <= PROD_W'(r_adc) * PROD_W'(n_ratio);
        end else if (i_cmd.mul_pct) begin
            r_prod <= PROD_W'(r_held_avg - r_empty_mv) * PROD_W'(PCT_FULL);
        end
        if (i_cmd.latch_adc) begin
            r_adc <= n_adc;
        end
        if (i_cmd.latch_mv) begin
            if (r_adc == '0) begin
                r_mv <= '0;
            end else if (n_quo > DW'(MV_MAX)) begin
                r_mv <= MV_MAX;
            end else begin
                r_mv <= n_quo[MV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pct   <= r_held_pct;
            r_out_avg   <= r_held_avg;
            r_out_taken <= n_taken;
        end
    end

    assign o_status.div_done     = n_div_done;
    assign o_status.taken        = n_taken;
    assign o_status.pct_in_range = !n_ge_full && !n_le_empty;
    assign o_status.out_free     = n_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_level_percent = r_out_pct;
    assign o_average_mv    = r_out_avg;
    assign o_sample_taken  = r_out_taken;
endmodule

// File: sv/blavg_ctrl.sv
module blavg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  blavg_pkg::t_status i_status,
    output blavg_pkg::t_cmd    o_cmd
);
    import blavg_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        n_cmd.div_sel = DS_RATIO;
        unique case (r_state)
            S_IDLE: begin
                n_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd.load_in = 1'b1;
                    n_state       = S_MUL_ADC;
                end
            end
            S_MUL_ADC: begin
                n_cmd.mul_adc = 1'b1;
                n_state       = S_ADC;
            end
            S_ADC: begin
                n_cmd.latch_adc = 1'b1;
                n_state         = S_MUL_RAT;
            end
            S_MUL_RAT: begin
                n_cmd.mul_ratio = 1'b1;
                n_state         = S_GO_RAT;
            end
            S_GO_RAT: begin
                n_cmd.div_go  = 1'b1;
                n_cmd.div_sel = DS_RATIO;
                n_state       = S_DIV_RAT;
            end
            S_DIV_RAT: begin
                n_cmd.div_sel = DS_RATIO;
                if (i_status.div_done) begin
                    n_cmd.latch_mv = 1'b1;
                    n_state        = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_status.taken) begin
                    n_cmd.update = 1'b1;
                    n_state      = S_GO_AVG;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_GO_AVG: begin
                n_cmd.div_go  = 1'b1;
                n_cmd.div_sel = DS_AVG;
                n_state       = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                n_cmd.div_sel = DS_AVG;
                if (i_status.div_done) begin
                    n_cmd.latch_avg = 1'b1;
                    n_state         = S_PCT;
                end
            end
            S_PCT: begin
                if (i_status.pct_in_range) begin
                    n_cmd.mul_pct = 1'b1;
                    n_state       = S_GO_PCT;
                end else begin
                    n_cmd.pct_direct = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_GO_PCT: begin
                n_cmd.div_go  = 1'b1;
                n_cmd.div_sel = DS_PCT;
                n_state       = S_DIV_PCT;
            end
            S_DIV_PCT: begin
                n_cmd.div_sel = DS_PCT;
                if (i_status.div_done) begin
                    n_cmd.latch_pct = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = n_cmd;
endmodule

// File: sv/battery_level_averager.sv
// Battery level averager.
// Input channel i_in carries one converter request: raw_sample and read_ok.
// Output channel o_out returns one result per request: level_percent,
// average_mv and sample_taken.
// Each request is processed on its own by a controller and a datapath. The
// division by 4095 folds the halves of the product combinationally; the divisions
// by register values share one radix-2 divider (one quotient bit per cycle, 24
// bits wide for the default window). A request with a failed read or a zero
// voltage skips the window update and the averaging; a taken request needs the
// third division only when the level falls between empty and full. The
// divider sets the throughput: the next request is accepted only once the
// result of the last one has been loaded into the output register.
// The result sits in an output register: the next request is accepted while
// it waits, and a stalled receiver holds processing only at the hand-over of
// the following result.
// Reset (synchronous, active low) holds i_in.ready low, clears the window, the
// running sum and the average, sets the level to 100 and loads the default
// register values. The sample ring is not cleared; an entry is read back only
// once written. Registers are written through i_cfg_we, i_cfg_idx, i_cfg_data.
module battery_level_averager #(
    parameter int WINDOW_SAMPLES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    blavg_in_if.sink                         i_in,
    blavg_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [blavg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [blavg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import blavg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    blavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    blavg_datapath #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_raw_sample    (i_in.raw_sample),
        .i_read_ok       (i_in.read_ok),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_level_percent (o_out.level_percent),
        .o_average_mv    (o_out.average_mv),
        .o_sample_taken  (o_out.sample_taken)
    );

    assign i_in.ready = w_cmd.in_ready && i_rst_n;
endmodule

// File: sv/blavg_checker.sv
module blavg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [6:0]  i_level_percent,
    input logic [15:0] i_average_mv,
    input logic        i_sample_taken
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_level_percent <= 7'd100)
        else $error("level above 100 percent");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    a_taken_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sample_taken |-> i_average_mv != 16'd0)
        else $error("taken sample with zero average");
endmodule

bind battery_level_averager blavg_checker u_blavg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_level_percent (o_out.level_percent),
    .i_average_mv    (o_out.average_mv),
    .i_sample_taken  (o_out.sample_taken)
);

// File: verif/battery_level_averager_tb.sv
module battery_level_averager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blavg_pkg::*;

    localparam int WINDOW      = 16;
    localparam int POS_W       = $clog2(WINDOW);
    localparam int PAD_W       = CFG_DATA_W - RES_W;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 1500;
    localparam int TAIL_CYCLES = 250;

    typedef struct packed {
        logic [PCT_W-1:0] level_percent;
        logic [MV_W-1:0]  average_mv;
        logic             sample_taken;
    } t_gauge_reading;

    typedef enum logic [1:0] {
        RCV_ALWAYS,
        RCV_RANDOM,
        RCV_PATTERN
    } t_rcv_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    blavg_in_if  sample_ch ();
    blavg_out_if level_ch ();

    battery_level_averager #(
        .WINDOW_SAMPLES(WINDOW)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (sample_ch),
        .o_out     (level_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // gauge model state
    logic [RES_W-1:0] div_upper_kohm = RST_UPPER_KOHM;
    logic [RES_W-1:0] div_lower_kohm = RST_LOWER_KOHM;
    logic [MV_W-1:0]  full_mv        = RST_FULL_MV;
    logic [MV_W-1:0]  empty_mv       = RST_EMPTY_MV;
    logic [MV_W-1:0]  voltage_ring [WINDOW];
    logic [POS_W-1:0] ring_pos       = '0;
    bit               ring_wrapped   = 1'b0;
    logic [19:0]      voltage_sum    = '0;
    logic [MV_W-1:0]  avg_mv         = '0;
    logic [PCT_W-1:0] level_pct      = PCT_FULL;

    t_gauge_reading   expected_readings [$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;

    bit               gaps_on        = 1'b0;
    int               burst_left     = 0;
    t_rcv_style       stall_style    = RCV_ALWAYS;
    logic [7:0]       stall_pattern  = 8'hFF;
    logic [2:0]       pattern_pos    = '0;
    bit               hold_toggle    = 1'b0;
    bit               hold_seen      = 1'b0;
    int               hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_gauge_reading predict_gauge(input logic [RAW_W-1:0] raw,
                                                     input logic ok);
        int unsigned    adc_mv;
        int unsigned    volts;
        int unsigned    span;
        int unsigned    above;
        t_gauge_reading reading;
        adc_mv = raw;
        adc_mv = adc_mv * ADC_FULL_MV / ADC_MAX_CODE;
        if (div_lower_kohm == 0) begin
            volts = (adc_mv != 0) ? MV_MAX : 0;
        end else begin
            volts = adc_mv * (div_upper_kohm + div_lower_kohm) / div_lower_kohm;
            if (volts > MV_MAX) begin
                volts = MV_MAX;
            end
        end
        reading.sample_taken = ok && (volts != 0);
        if (reading.sample_taken) begin
            // drop the oldest voltage once the window has wrapped
            if (ring_wrapped) begin
                voltage_sum = voltage_sum - voltage_ring[ring_pos];
            end
            voltage_ring[ring_pos] = volts[MV_W-1:0];
            voltage_sum = voltage_sum + volts[MV_W-1:0];
            if (ring_pos == POS_W'(WINDOW - 1)) begin
                ring_pos = '0;
                ring_wrapped = 1'b1;
            end else begin
                ring_pos = ring_pos + 1'b1;
            end
            avg_mv = MV_W'(voltage_sum / (ring_wrapped ? WINDOW : int'(ring_pos)));
            if (avg_mv >= full_mv) begin
                level_pct = PCT_FULL;
            end else if (avg_mv <= empty_mv) begin
                level_pct = PCT_EMPTY;
            end else begin
                span  = full_mv - empty_mv;
                above = avg_mv - empty_mv;
                level_pct = PCT_W'(above * PCT_FULL / span);
            end
        end
        reading.level_percent = level_pct;
        reading.average_mv    = avg_mv;
        return reading;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            expected_readings.push_back(predict_gauge(sample_ch.raw_sample,
                                                      sample_ch.read_ok));
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_readings
        t_gauge_reading want;
        if (i_rst_n && level_ch.valid && level_ch.ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("result with no request pending", level_ch.average_mv, 0);
            end else begin
                want = expected_readings.pop_front();
                if (level_ch.level_percent !== want.level_percent) begin
                    report_mismatch("level_percent", level_ch.level_percent,
                                    want.level_percent);
                end
                if (level_ch.average_mv !== want.average_mv) begin
                    report_mismatch("average_mv", level_ch.average_mv, want.average_mv);
                end
                if (level_ch.sample_taken !== want.sample_taken) begin
                    report_mismatch("sample_taken", level_ch.sample_taken,
                                    want.sample_taken);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen      <= hold_toggle;
            hold_left      <= LONG_HOLD;
            level_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            level_ch.ready <= 1'b0;
        end else begin
            case (stall_style)
                RCV_ALWAYS: begin
                    level_ch.ready <= 1'b1;
                end
                RCV_RANDOM: begin
                    level_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    level_ch.ready <= stall_pattern[pattern_pos];
                    pattern_pos    <= pattern_pos + 1'b1;
                end
            endcase
        end
    end

    task automatic offer_sample(input logic [RAW_W-1:0] raw, input logic ok);
        sample_ch.valid      <= 1'b1;
        sample_ch.raw_sample <= raw;
        sample_ch.read_ok    <= ok;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                sample_ch.valid <= 1'b0;
                burst_left = $urandom_range(1, 12);
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 130)
                                                     : $urandom_range(1, 8))
                    @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_UPPER_KOHM: div_upper_kohm = data[RES_W-1:0];
            REG_LOWER_KOHM: div_lower_kohm = data[RES_W-1:0];
            REG_FULL_MV:    full_mv        = data;
            REG_EMPTY_MV:   empty_mv       = data;
        endcase
    endtask

    task automatic load_settings(input logic [RES_W-1:0] upper,
                                 input logic [RES_W-1:0] lower,
                                 input logic [MV_W-1:0]  full,
                                 input logic [MV_W-1:0]  empty);
        logic [PAD_W-1:0] pad_bits;
        drain_results();
        // upper data bits above the resistor width must be dropped
        pad_bits = PAD_W'($urandom);
        write_reg(REG_UPPER_KOHM, {pad_bits, upper});
        pad_bits = PAD_W'($urandom);
        write_reg(REG_LOWER_KOHM, {pad_bits, lower});
        write_reg(REG_FULL_MV, full);
        write_reg(REG_EMPTY_MV, empty);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        offer_sample(12'd4095, 1'b0);
        offer_sample(12'd0, 1'b1);
        offer_sample(12'd1, 1'b1);
        offer_sample(12'd2, 1'b1);
        offer_sample(12'd4095, 1'b1);
        offer_sample(12'd2192, 1'b1);
        offer_sample(12'd2192, 1'b0);
        drain_results();
    endtask

    task automatic test_divider_extremes();
        load_settings(10'd0, 10'd0, 16'd65535, 16'd0);
        offer_sample(12'd1, 1'b1);
        offer_sample(12'd2, 1'b1);
        offer_sample(12'd4095, 1'b1);
        load_settings(10'd1023, 10'd1, 16'd1, 16'd0);
        offer_sample(12'd2, 1'b1);
        offer_sample(12'd4095, 1'b1);
        load_settings(10'd0, 10'd1023, 16'd3000, 16'd3000);
        offer_sample(12'd3460, 1'b1);
        offer_sample(12'd4095, 1'b1);
        load_settings(10'd1023, 10'd1023, 16'd65535, 16'd65534);
        offer_sample(12'd4095, 1'b1);
        offer_sample(12'd3000, 1'b1);
        load_settings(10'd512, 10'd1000, 16'd500, 16'd4000);
        offer_sample(12'd100, 1'b1);
        offer_sample(12'd4000, 1'b1);
        drain_results();
    endtask

    task automatic test_backpressure();
        int k;
        gaps_on = 1'b0;
        stall_style <= RCV_ALWAYS;
        // hold off the receiver so requests back up into the input
        hold_toggle <= ~hold_toggle;
        for (k = 0; k < 12; k++) begin
            offer_sample(RAW_W'($urandom), 1'b1);
        end
        drain_results();
    endtask

    task automatic run_random_phase(input int n_items);
        int               center;
        int               spread;
        int               est;
        int               jitter;
        int               k;
        int               pick;
        logic [RES_W-1:0] up;
        logic [RES_W-1:0] lo;
        logic [MV_W-1:0]  fu;
        logic [MV_W-1:0]  em;
        logic             ok;
        center = $urandom_range(0, 4095);
        spread = $urandom_range(4, 300);
        case ($urandom_range(0, 5))
            0: begin
                up = '0;
                lo = RES_W'($urandom_range(1, 1023));
            end
            1: begin
                up = '1;
                lo = 10'd1;
            end
            2: begin
                up = RES_W'($urandom_range(0, 1023));
                lo = '0;
            end
            default: begin
                up = RES_W'($urandom_range(0, 400));
                lo = RES_W'($urandom_range(1, 1023));
            end
        endcase
        if (lo == 0) begin
            est = (center > 1) ? MV_MAX : 0;
        end else begin
            est = center * ADC_FULL_MV / ADC_MAX_CODE * (up + lo) / lo;
            if (est > MV_MAX) begin
                est = MV_MAX;
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            fu = MV_W'($urandom);
            em = MV_W'($urandom);
        end else begin
            jitter = $urandom_range(0, 1500);
            em = (est > jitter) ? MV_W'(est - jitter) : '0;
            jitter = $urandom_range(1, 1500);
            fu = (est + jitter > MV_MAX) ? MV_MAX : MV_W'(est + jitter);
        end
        load_settings(up, lo, fu, em);

        gaps_on = ($urandom_range(0, 3) != 0);
        burst_left = 0;
        case ($urandom_range(0, 2))
            0: stall_style <= RCV_ALWAYS;
            1: stall_style <= RCV_RANDOM;
            default: begin
                stall_style   <= RCV_PATTERN;
                stall_pattern <= 8'($urandom) | 8'h01;
            end
        endcase

        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                jitter = $urandom_range(0, 2 * spread);
                pick = center + jitter - spread;
                if (pick < 0) begin
                    pick = 0;
                end else if (pick > 4095) begin
                    pick = 4095;
                end
            end else if (pick < 88) begin
                pick = $urandom_range(0, 4095);
            end else begin
                pick = $urandom_range(0, 2);
            end
            ok = ($urandom_range(0, 9) != 0);
            offer_sample(RAW_W'(pick), ok);
        end
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 8; p++) begin
            run_random_phase(52);
        end
        drain_results();
    endtask

    initial begin
        cfg_we               <= 1'b0;
        cfg_idx              <= '0;
        cfg_data             <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.raw_sample <= '0;
        sample_ch.read_ok    <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_divider_extremes();
        test_backpressure();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
